// ----- rtl/sres_pkg.sv -----
// ----------------------------------------------------------------------------
// Sine ramp switch envelope - shared definitions
// Phase codes, register indexes, Q1.16 ramp constants and reset values.
// ----------------------------------------------------------------------------
package sres_pkg;

	localparam int SINE_TABLE_DEPTH_DEF = 1024;
	localparam int SAMPLE_WIDTH_DEF     = 24;

	localparam int LEN_W   = 16;
	localparam int STEP_W  = 17;
	localparam int POS_W   = 17;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 17;

	// Q1.16 unity and rounding half
	localparam logic [POS_W-1:0] POS_ONE   = 17'h10000;
	localparam int               ROUND_HALF = 32768;
	localparam int               FRAC_BITS  = 16;

	// pi/2 in Q30, seed of the quarter-sine table
	localparam longint HALF_PI_Q30 = 64'd1686629713;

	localparam logic [LEN_W-1:0]  FALL_LEN_RST  = 16'd240;
	localparam logic [LEN_W-1:0]  HOLD_LEN_RST  = 16'd2400;
	localparam logic [LEN_W-1:0]  RISE_LEN_RST  = 16'd240;
	localparam logic [STEP_W-1:0] FALL_STEP_RST = 17'd273;
	localparam logic [STEP_W-1:0] RISE_STEP_RST = 17'd273;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_FALL = 2'd1,
		PH_HOLD = 2'd2,
		PH_RISE = 2'd3
	} phase_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FALL_LEN  = 3'd0,
		CFG_HOLD_LEN  = 3'd1,
		CFG_RISE_LEN  = 3'd2,
		CFG_FALL_STEP = 3'd3,
		CFG_RISE_STEP = 3'd4
	} cfg_idx_t;

endpackage

// ----- rtl/sres_scale.sv -----
// ----------------------------------------------------------------------------
// Sine ramp switch envelope - channel scaler
// Multiply one sample by a Q1.16 weight, round half up, register the result.
// ----------------------------------------------------------------------------
module sres_scale
	import sres_pkg::*;
#(
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           en,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	input  logic        [POS_W-1:0]        weight,
	output logic signed [SAMPLE_WIDTH-1:0] result_s2
);

	localparam int PW = SAMPLE_WIDTH + POS_W + 1;

	logic signed [PW-1:0] prod;
	logic signed [PW-1:0] rnd;
	logic signed [PW-1:0] shifted;

	always_comb begin
		prod    = PW'(sample) * PW'(signed'({1'b0, weight}));
		rnd     = prod + PW'(ROUND_HALF);
		shifted = rnd >>> FRAC_BITS;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			result_s2 <= shifted[SAMPLE_WIDTH-1:0];
		end
	end

endmodule

// ----- rtl/sine_ramp_switch_envelope_core.sv -----
// ----------------------------------------------------------------------------
// Sine ramp switch envelope - top level
// Click-free mode switch: cosine fade-out, muted hold, quarter-sine fade-in.
// ----------------------------------------------------------------------------
// Usage
//   s_axis carries one four-channel frame per beat: tdata holds main left,
//   main right, aux left, aux right; tuser holds start_req and target_mode.
//   m_axis returns one weighted frame per input beat, in order; tuser gives
//   the phase of that frame and the mode in force after it, tlast marks the
//   frame that ends the fade-in (the new mode is adopted on that frame).
//   cfg writes ramp lengths and steps; cfg_ready is always high. Write only
//   while no frame is in flight.
// Pipeline and throughput
//   The envelope state and the sine table address settle in the accept
//   cycle, the table read is registered in stage 1, and the four
//   multipliers feed the output register. One frame per cycle sustained
//   while m_axis_tready stays high.
// Reset
//   arst_n clears the envelope to idle, receive mode, and loads the default
//   lengths (240 / 2400 / 240) and steps (273). The table is constant.
// Back-pressure
//   When m_axis_tready is low with a beat waiting, the whole pipe holds and
//   s_axis_tready drops in the same cycle; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module sine_ramp_switch_envelope_core
	import sres_pkg::*;
#(
	parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF,
	parameter int SAMPLE_WIDTH     = SAMPLE_WIDTH_DEF,
	localparam int TDATA_W = ((4 * SAMPLE_WIDTH + 7) / 8) * 8
) (
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// main_left, main_right, aux_left, aux_right, zero pad
	input  logic [TDATA_W-1:0]    s_axis_tdata,
	// start_req, target_mode
	input  logic [1:0]            s_axis_tuser,

	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// out_main_left, out_main_right, out_aux_left, out_aux_right, zero pad
	output logic [TDATA_W-1:0]    m_axis_tdata,
	// phase (2 bits), current_mode
	output logic [2:0]            m_axis_tuser,
	// done_res
	output logic                  m_axis_tlast,

	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH + 1);
	localparam int PROD_W = POS_W + IDX_W;

	typedef enum logic [1:0] {
		W_PASS = 2'd0,
		W_ZERO = 2'd1,
		W_ROM  = 2'd2
	} wsel_t;

	typedef logic [POS_W-1:0] rom_t [0:SINE_TABLE_DEPTH];

	// sin(pi/2 * k/DEPTH) in Q1.16: Q30 Taylor series, rounded half up, capped at 1.0
	function automatic rom_t build_rom();
		rom_t   r;
		longint x;
		longint x2;
		longint term;
		longint sum;
		longint w;
		for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
			x    = (HALF_PI_Q30 * longint'(k)) / SINE_TABLE_DEPTH;
			x2   = (x * x) >>> 30;
			// nine alternating terms, each divided by (2n)(2n+1)
			term = ((x * x2) >>> 30) / 64'sd6;
			sum  = x - term;
			term = ((term * x2) >>> 30) / 64'sd20;
			sum  = sum + term;
			term = ((term * x2) >>> 30) / 64'sd42;
			sum  = sum - term;
			term = ((term * x2) >>> 30) / 64'sd72;
			sum  = sum + term;
			term = ((term * x2) >>> 30) / 64'sd110;
			sum  = sum - term;
			term = ((term * x2) >>> 30) / 64'sd156;
			sum  = sum + term;
			term = ((term * x2) >>> 30) / 64'sd210;
			sum  = sum - term;
			term = ((term * x2) >>> 30) / 64'sd272;
			sum  = sum + term;
			term = ((term * x2) >>> 30) / 64'sd342;
			sum  = sum - term;
			if (sum < 0) begin
				sum = 0;
			end
			w = (sum + 8192) >>> 14;
			if (w > longint'(POS_ONE)) begin
				w = longint'(POS_ONE);
			end
			r[k] = POS_W'(w);
		end
		return r;
	endfunction

	localparam rom_t SINE_ROM = build_rom();

	// configuration registers
	logic [LEN_W-1:0]  fall_len_q, hold_len_q, rise_len_q;
	logic [STEP_W-1:0] fall_step_q, rise_step_q;

	// envelope state
	phase_t            phase_q;
	logic [LEN_W-1:0]  count_q;
	logic [POS_W-1:0]  pos_q;
	logic              pending_q;
	logic              mode_q;

	// next-state logic
	logic              adv;
	logic              in_acc;
	logic              start;
	phase_t            ph_cur;
	phase_t            phase_nxt;
	logic [LEN_W-1:0]  cnt_base;
	logic [LEN_W:0]    cnt_inc;
	logic [LEN_W-1:0]  count_nxt;
	logic [POS_W-1:0]  pos_base;
	logic [POS_W-1:0]  pos_nxt;
	logic [STEP_W-1:0] step;
	logic [POS_W:0]    pos_sum;
	logic [POS_W-1:0]  pos_adv;
	logic              pending_nxt;
	logic              mode_nxt;
	logic              done;
	wsel_t             wsel;
	logic [PROD_W-1:0] idx_prod;
	logic [IDX_W-1:0]  rom_idx;
	logic [IDX_W-1:0]  rom_addr;

	// stage 1
	logic                           vld_s1;
	logic [SAMPLE_WIDTH-1:0]        smp_s1 [4];
	wsel_t                          wsel_s1;
	logic [POS_W-1:0]               rom_s1;
	phase_t                         phase_s1;
	logic                           done_s1;
	logic                           mode_s1;
	logic [POS_W-1:0]               weight;

	// stage 2 (output register)
	logic                           vld_s2;
	logic signed [SAMPLE_WIDTH-1:0] res_s2 [4];
	phase_t                         phase_s2;
	logic                           done_s2;
	logic                           mode_s2;

	// Advance the pipe whenever the output slot is free or being emptied
	assign adv           = !vld_s2 || m_axis_tready;
	assign s_axis_tready = adv;
	assign in_acc        = s_axis_tvalid && adv;
	assign cfg_ready     = 1'b1;

	// Register writes; unknown indexes drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fall_len_q  <= FALL_LEN_RST;
			hold_len_q  <= HOLD_LEN_RST;
			rise_len_q  <= RISE_LEN_RST;
			fall_step_q <= FALL_STEP_RST;
			rise_step_q <= RISE_STEP_RST;
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				CFG_FALL_LEN:  fall_len_q  <= cfg_data[LEN_W-1:0];
				CFG_HOLD_LEN:  hold_len_q  <= cfg_data[LEN_W-1:0];
				CFG_RISE_LEN:  rise_len_q  <= cfg_data[LEN_W-1:0];
				CFG_FALL_STEP: fall_step_q <= cfg_data[STEP_W-1:0];
				CFG_RISE_STEP: rise_step_q <= cfg_data[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	// Envelope sequencer: a start in idle makes this frame the first fall frame.
	// A zero length compares as reached on the first frame, so it acts as one.
	always_comb begin
		start       = (phase_q == PH_IDLE) && s_axis_tuser[0];
		ph_cur      = start ? PH_FALL : phase_q;
		cnt_base    = start ? '0 : count_q;
		pos_base    = start ? '0 : pos_q;
		cnt_inc     = {1'b0, cnt_base} + (LEN_W + 1)'(1);
		step        = (ph_cur == PH_RISE) ? rise_step_q : fall_step_q;
		pos_sum     = {1'b0, pos_base} + {1'b0, step};
		pos_adv     = (pos_sum > {1'b0, POS_ONE}) ? POS_ONE : pos_sum[POS_W-1:0];
		pending_nxt = start ? s_axis_tuser[1] : pending_q;
		phase_nxt   = ph_cur;
		count_nxt   = cnt_base;
		pos_nxt     = pos_base;
		mode_nxt    = mode_q;
		done        = 1'b0;
		wsel        = W_PASS;
		case (ph_cur)
			PH_FALL: begin
				wsel      = W_ROM;
				pos_nxt   = pos_adv;
				count_nxt = cnt_inc[LEN_W-1:0];
				if (cnt_inc >= {1'b0, fall_len_q}) begin
					phase_nxt = PH_HOLD;
					count_nxt = '0;
					pos_nxt   = '0;
				end
			end
			PH_HOLD: begin
				wsel      = W_ZERO;
				count_nxt = cnt_inc[LEN_W-1:0];
				if (cnt_inc >= {1'b0, hold_len_q}) begin
					phase_nxt = PH_RISE;
					count_nxt = '0;
					pos_nxt   = '0;
				end
			end
			PH_RISE: begin
				wsel      = W_ROM;
				pos_nxt   = pos_adv;
				count_nxt = cnt_inc[LEN_W-1:0];
				if (cnt_inc >= {1'b0, rise_len_q}) begin
					phase_nxt = PH_IDLE;
					count_nxt = '0;
					pos_nxt   = '0;
					mode_nxt  = pending_nxt;
					done      = 1'b1;
				end
			end
			default: ;
		endcase

		// table index of the advanced position, rounded; the fall reads mirrored
		idx_prod = PROD_W'(pos_adv) * PROD_W'(SINE_TABLE_DEPTH) + PROD_W'(ROUND_HALF);
		rom_idx  = IDX_W'(idx_prod >> FRAC_BITS);
		rom_addr = (ph_cur == PH_RISE) ? rom_idx : IDX_W'(SINE_TABLE_DEPTH) - rom_idx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			count_q   <= '0;
			pos_q     <= '0;
			pending_q <= 1'b0;
			mode_q    <= 1'b0;
		end else if (in_acc) begin
			phase_q   <= phase_nxt;
			count_q   <= count_nxt;
			pos_q     <= pos_nxt;
			pending_q <= pending_nxt;
			mode_q    <= mode_nxt;
		end
	end

	// Stage 1: capture the frame and read the sine table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= s_axis_tvalid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int j = 0; j < 4; j++) begin
				smp_s1[j] <= s_axis_tdata[j*SAMPLE_WIDTH +: SAMPLE_WIDTH];
			end
			wsel_s1  <= wsel;
			rom_s1   <= SINE_ROM[rom_addr];
			phase_s1 <= ph_cur;
			done_s1  <= done;
			mode_s1  <= mode_nxt;
		end
	end

	// Idle passes at unity, hold mutes
	always_comb begin
		case (wsel_s1)
			W_PASS:  weight = POS_ONE;
			W_ZERO:  weight = '0;
			W_ROM:   weight = rom_s1;
			default: weight = POS_ONE;
		endcase
	end

	// Stage 2: four multipliers into the output register
	for (genvar g = 0; g < 4; g++) begin : g_chan
		sres_scale #(
			.SAMPLE_WIDTH(SAMPLE_WIDTH)
		) u_scale (
			.clk       (clk),
			.en        (adv),
			.sample    (signed'(smp_s1[g])),
			.weight    (weight),
			.result_s2 (res_s2[g])
		);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			phase_s2 <= phase_s1;
			done_s2  <= done_s1;
			mode_s2  <= mode_s1;
		end
	end

	always_comb begin
		m_axis_tdata = '0;
		for (int j = 0; j < 4; j++) begin
			m_axis_tdata[j*SAMPLE_WIDTH +: SAMPLE_WIDTH] = res_s2[j];
		end
	end

	assign m_axis_tvalid = vld_s2;
	assign m_axis_tuser  = {mode_s2, phase_s2};
	assign m_axis_tlast  = done_s2;

endmodule

// ----- rtl/sres_checker.sv -----
// ----------------------------------------------------------------------------
// Sine ramp switch envelope - port checker
// Watches the top level's ports for envelope and handshake slips.
// ----------------------------------------------------------------------------
module sres_checker
	import sres_pkg::*;
#(
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
	localparam int TDATA_W = ((4 * SAMPLE_WIDTH + 7) / 8) * 8
) (
	input logic               clk,
	input logic               arst_n,
	input logic               s_axis_tready,
	input logic               m_axis_tvalid,
	input logic               m_axis_tready,
	input logic [TDATA_W-1:0] m_axis_tdata,
	input logic [2:0]         m_axis_tuser,
	input logic               m_axis_tlast
);

	// done only on a rise frame
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[1:0] == PH_RISE)
		else $error("done beat outside the rise phase");

	// hold frames are muted
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1:0] == PH_HOLD |-> m_axis_tdata == '0)
		else $error("hold beat carries non-zero samples");

	// an empty output slot never blocks the input
	assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with output empty");

	// a stalled beat holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("stalled output beat changed");

endmodule

bind sine_ramp_switch_envelope_core sres_checker #(
	.SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_sres_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);

// ----- bench/sine_ramp_switch_envelope_core_tb.sv -----
// ----------------------------------------------------------------------------
// Sine ramp switch envelope - self-checking bench
// Drives four-channel frames through the envelope core and checks every
// output beat against a cycle-free model of the fall / hold / rise sequence.
// A short table covers passthrough extremes, zero lengths and steps,
// saturating steps, masked and ignored register writes, then random phases
// reprogram the ramps and stream frames with random gaps and back-pressure.
// ----------------------------------------------------------------------------
module sine_ramp_switch_envelope_core_tb;
	import sres_pkg::*;

	localparam int SW          = SAMPLE_WIDTH_DEF;
	localparam int DEPTH       = SINE_TABLE_DEPTH_DEF;
	localparam int TDW         = ((4 * SW + 7) / 8) * 8;
	localparam int FRAME_TARGET = 1650;
	localparam int STALL_LIMIT = 2000;  // cycles without any beat before giving up
	localparam int HOLD_OFF    = 200;   // long receiver hold-off, fills the pipe
	localparam int SETTLE      = 8;     // margin over the pipeline latency

	// pi/2 in Q30, seed of the quarter-sine table
	localparam longint QUARTER_TURN_Q30 = 64'sd1686629713;

	// register indexes past the end of the map, writes there are dropped
	localparam logic [CFG_IDX_W-1:0] CFG_NONE_LO = CFG_IDX_W'(CFG_RISE_STEP + 1);
	localparam logic [CFG_IDX_W-1:0] CFG_NONE_HI = '1;

	localparam logic [SW-1:0] SAMPLE_MAX = {1'b0, {(SW-1){1'b1}}};
	localparam logic [SW-1:0] SAMPLE_MIN = {1'b1, {(SW-1){1'b0}}};
	localparam logic [SW-1:0] SAMPLE_ONE = {{(SW-1){1'b0}}, 1'b1};

	typedef struct packed {
		logic                 start;
		logic                 target;
		logic [3:0][SW-1:0]   ch;      // main left, main right, aux left, aux right
	} in_frame_t;

	typedef struct packed {
		logic [3:0][SW-1:0]   ch;
		phase_t               ph;
		logic                 done;
		logic                 mode;
	} out_frame_t;

	// how a directed row is checked: by the model, or by a value typed in
	typedef enum logic [1:0] {
		CHK_PREDICT,
		CHK_PASS,
		CHK_ZERO
	} row_check_t;

	typedef struct packed {
		logic                  is_reg;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] val;
		in_frame_t             f;
		row_check_t            chk;
		phase_t                ph;
		logic                  done;
		logic                  mode;
	} dir_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [TDW-1:0]        s_axis_tdata = '0;  // main_left, main_right, aux_left, aux_right
	logic [1:0]            s_axis_tuser = '0;  // start_req, target_mode
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [TDW-1:0]        m_axis_tdata;       // out_main_left .. out_aux_right
	logic [2:0]            m_axis_tuser;       // phase (2 bits), current_mode
	logic                  m_axis_tlast;       // done_res
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	sine_ramp_switch_envelope_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Envelope model: register copies, sequence state and sine table
	// ------------------------------------------------------------------
	int unsigned cfg_fall_len, cfg_hold_len, cfg_rise_len, cfg_fall_step, cfg_rise_step;
	phase_t      env_phase;
	int unsigned env_count, env_pos;
	logic        env_pending, env_mode;
	int unsigned sine_tab [0:DEPTH];

	out_frame_t  expected_frames [$];
	int          frames_sent = 0;
	int          beats_checked = 0;
	int          switches_done = 0;
	int          reg_writes = 0;
	int          fail_count = 0;
	int          burst_left = 0;
	bit          hold_off_req = 1'b0;
	bit          hold_off_done = 1'b0;

	string chan_name [0:3] = '{"out_main_left", "out_main_right", "out_aux_left", "out_aux_right"};

	// sin(pi/2 * k/DEPTH) in Q16: Taylor series in Q30 with nine correction terms, truncating each step
	function automatic int unsigned quarter_sine(int k);
		longint x, x2, term, acc;
		longint unsigned w;
		x = (QUARTER_TURN_Q30 * longint'(k)) / longint'(DEPTH);
		x2 = (x * x) >>> 30;
		term = x;
		acc = x;
		for (int n = 1; n <= 9; n++) begin
			term = ((term * x2) >>> 30) / longint'((2 * n) * (2 * n + 1));
			if (n % 2 == 1) acc -= term;
			else acc += term;
		end
		if (acc < 0) acc = 0;
		w = (longint'(acc) + 8192) >> 14;
		if (w > POS_ONE) w = POS_ONE;
		return int'(w);
	endfunction

	function automatic int unsigned tab_index(int unsigned pos);
		return (pos * DEPTH + 32'd32768) >> 16;
	endfunction

	function automatic int unsigned ramp_advance(int unsigned pos, int unsigned step);
		return (pos + step > POS_ONE) ? POS_ONE : pos + step;
	endfunction

	// sample * weight in Q16, rounded half up; unity weight passes the sample as is
	function automatic logic [SW-1:0] weigh(logic [SW-1:0] s, int unsigned w);
		longint p;
		if (w == POS_ONE) return s;
		p = longint'($signed(s)) * longint'(w) + 64'sd32768;
		return SW'(p >>> 16);
	endfunction

	function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		case (idx)
			CFG_FALL_LEN:  cfg_fall_len  = val[LEN_W-1:0];
			CFG_HOLD_LEN:  cfg_hold_len  = val[LEN_W-1:0];
			CFG_RISE_LEN:  cfg_rise_len  = val[LEN_W-1:0];
			CFG_FALL_STEP: cfg_fall_step = val[STEP_W-1:0];
			CFG_RISE_STEP: cfg_rise_step = val[STEP_W-1:0];
			default: ;
		endcase
	endfunction

	// advance the envelope by one frame and return the frame it should emit
	function automatic out_frame_t envelope_predict(in_frame_t f);
		out_frame_t  o;
		int unsigned w, nxt;
		phase_t      ph;
		logic        done;
		w = POS_ONE;
		done = 1'b0;
		// a start request only counts from idle
		if (env_phase == PH_IDLE && f.start) begin
			env_pending = f.target;
			env_phase = PH_FALL;
			env_count = 0;
			env_pos = 0;
		end
		ph = env_phase;
		nxt = (env_count & 32'hFFFF) + 1;
		case (ph)
			PH_FALL: begin
				env_pos = ramp_advance(env_pos, cfg_fall_step);
				w = sine_tab[DEPTH - tab_index(env_pos)];
				if (nxt >= cfg_fall_len) begin
					env_phase = PH_HOLD;
					nxt = 0;
					env_pos = 0;
				end
				env_count = nxt;
			end
			PH_HOLD: begin
				w = 0;
				if (nxt >= cfg_hold_len) begin
					env_phase = PH_RISE;
					nxt = 0;
					env_pos = 0;
				end
				env_count = nxt;
			end
			PH_RISE: begin
				env_pos = ramp_advance(env_pos, cfg_rise_step);
				w = sine_tab[tab_index(env_pos)];
				if (nxt >= cfg_rise_len) begin
					env_mode = env_pending;
					env_phase = PH_IDLE;
					nxt = 0;
					env_pos = 0;
					done = 1'b1;
					switches_done++;
				end
				env_count = nxt;
			end
			default: ;
		endcase
		for (int j = 0; j < 4; j++) o.ch[j] = weigh(f.ch[j], w);
		o.ph = ph;
		o.done = done;
		o.mode = env_mode;
		return o;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	function automatic dir_row_t frame_row(logic st, logic tg,
			logic [SW-1:0] ml, logic [SW-1:0] mr, logic [SW-1:0] al, logic [SW-1:0] ar,
			row_check_t chk = CHK_PREDICT, phase_t ph = PH_IDLE,
			logic dn = 1'b0, logic md = 1'b0);
		dir_row_t r;
		r = '0;
		r.f.start = st;
		r.f.target = tg;
		r.f.ch = {ar, al, mr, ml};
		r.chk = chk;
		r.ph = ph;
		r.done = dn;
		r.mode = md;
		return r;
	endfunction

	function automatic dir_row_t reg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		dir_row_t r;
		r = '0;
		r.is_reg = 1'b1;
		r.idx = idx;
		r.val = val;
		return r;
	endfunction

	function automatic logic [SW-1:0] random_sample();
		if ($urandom_range(0, 6) != 0) return SW'($urandom);
		case ($urandom_range(0, 3))
			0: return SAMPLE_MAX;
			1: return SAMPLE_MIN;
			2: return '0;
			default: return '1;
		endcase
	endfunction

	function automatic in_frame_t random_frame();
		in_frame_t f;
		// mostly start requests, so idle spells stay short and switches chain up
		f.start = ($urandom_range(0, 9) < 6);
		f.target = 1'($urandom_range(0, 1));
		for (int j = 0; j < 4; j++) f.ch[j] = random_sample();
		return f;
	endfunction

	function automatic logic [CFG_DATA_W-1:0] random_length();
		int r;
		logic [CFG_DATA_W-1:0] v;
		r = $urandom_range(0, 99);
		if (r < 8) v = '0;
		else if (r < 13) v = CFG_DATA_W'(16'hFFFF);
		else if (r < 80) v = CFG_DATA_W'($urandom_range(1, 12));
		else v = CFG_DATA_W'($urandom_range(13, 400));
		// bit above the length width, the register drops it
		if ($urandom_range(0, 9) == 0) v[LEN_W] = 1'b1;
		return v;
	endfunction

	function automatic logic [CFG_DATA_W-1:0] random_step(logic [CFG_DATA_W-1:0] len);
		int r;
		int unsigned n;
		r = $urandom_range(0, 99);
		n = (len[LEN_W-1:0] == 0) ? 1 : len[LEN_W-1:0];
		if (r < 8) return '0;
		if (r < 16) return POS_ONE;
		if (r < 26) return CFG_DATA_W'($urandom_range(65537, 131071));
		if (r < 60) return CFG_DATA_W'((65536 + n - 1) / n);
		return CFG_DATA_W'($urandom_range(1, 65536));
	endfunction

	// offer one frame, after a random gap at the start of each burst
	task automatic send_frame(in_frame_t f);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 48);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_axis_tdata <= TDW'(f.ch);
		s_axis_tuser <= {f.target, f.start};
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	// stop offering and wait for every outstanding frame to come back
	task automatic drain_frames();
		s_axis_tvalid <= 1'b0;
		while (expected_frames.size() != 0) @(posedge clk);
	endtask

	// leaves cfg_valid high; the caller drops it after the last write
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		apply_reg(idx, val);
		reg_writes++;
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin : main_seq
		dir_row_t              directed_rows [$];
		dir_row_t              row;
		out_frame_t            want;
		in_frame_t             f;
		logic                  prev_reg;
		int                    phase_no;
		int                    batch;
		logic [CFG_DATA_W-1:0] fl, hl, rl, fs, rs;

		for (int k = 0; k <= DEPTH; k++) sine_tab[k] = quarter_sine(k);
		cfg_fall_len = 240;
		cfg_hold_len = 2400;
		cfg_rise_len = 240;
		cfg_fall_step = 273;
		cfg_rise_step = 273;
		env_phase = PH_IDLE;
		env_count = 0;
		env_pos = 0;
		env_pending = 1'b0;
		env_mode = 1'b0;

		// idle after reset: extremes pass straight through in receive mode
		directed_rows.push_back(frame_row(1'b0, 1'b1, SAMPLE_MAX, SAMPLE_MIN, '0, '1,
			CHK_PASS, PH_IDLE, 1'b0, 1'b0));
		directed_rows.push_back(frame_row(1'b0, 1'b0, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_ONE,
			~SAMPLE_ONE, CHK_PASS, PH_IDLE, 1'b0, 1'b0));
		directed_rows.push_back(frame_row(1'b0, 1'b1, 24'h5A5A5A, 24'hA5A5A5, 24'h0F0F0F,
			24'hF0F0F0, CHK_PASS, PH_IDLE, 1'b0, 1'b0));
		// zero fall length, zero fall step, rise step beyond unity, rise length
		// with a bit above the register width (masked down to two)
		directed_rows.push_back(reg_row(CFG_FALL_LEN, '0));
		directed_rows.push_back(reg_row(CFG_HOLD_LEN, 17'd1));
		directed_rows.push_back(reg_row(CFG_RISE_LEN, 17'h10002));
		directed_rows.push_back(reg_row(CFG_FALL_STEP, '0));
		directed_rows.push_back(reg_row(CFG_RISE_STEP, 17'h1FFFF));
		// fall at position zero keeps unity weight
		directed_rows.push_back(frame_row(1'b1, 1'b1, SAMPLE_MAX, SAMPLE_MIN, '1, SAMPLE_ONE,
			CHK_PASS, PH_FALL, 1'b0, 1'b0));
		// start while running is dropped, hold mutes
		directed_rows.push_back(frame_row(1'b1, 1'b0, SAMPLE_MAX, SAMPLE_MIN, '1, SAMPLE_ONE,
			CHK_ZERO, PH_HOLD, 1'b0, 1'b0));
		// saturated rise position gives unity weight
		directed_rows.push_back(frame_row(1'b0, 1'b0, SAMPLE_MIN, SAMPLE_MAX, 24'h123456,
			24'h876543, CHK_PASS, PH_RISE, 1'b0, 1'b0));
		directed_rows.push_back(frame_row(1'b0, 1'b0, SAMPLE_MAX, 24'h000100, SAMPLE_MIN,
			'0, CHK_PASS, PH_RISE, 1'b1, 1'b1));
		directed_rows.push_back(frame_row(1'b0, 1'b0, '1, SAMPLE_ONE, SAMPLE_MAX, SAMPLE_MIN,
			CHK_PASS, PH_IDLE, 1'b0, 1'b1));
		// writes past the register map must leave the envelope untouched
		directed_rows.push_back(reg_row(CFG_NONE_LO, 17'h1FFFF));
		directed_rows.push_back(reg_row(CFG_IDX_W'(CFG_NONE_LO + 1), '0));
		directed_rows.push_back(reg_row(CFG_NONE_HI, 17'd1));
		// fall step of exactly unity: fall weight zero; rise step zero: rise weight zero
		directed_rows.push_back(reg_row(CFG_FALL_STEP, POS_ONE));
		directed_rows.push_back(reg_row(CFG_RISE_STEP, '0));
		directed_rows.push_back(frame_row(1'b1, 1'b0, SAMPLE_MAX, SAMPLE_MIN, '1, 24'h7ABCDE,
			CHK_ZERO, PH_FALL, 1'b0, 1'b1));
		directed_rows.push_back(frame_row(1'b0, 1'b1, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_ONE,
			'1, CHK_ZERO, PH_HOLD, 1'b0, 1'b1));
		directed_rows.push_back(frame_row(1'b1, 1'b1, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN,
			SAMPLE_MIN, CHK_ZERO, PH_RISE, 1'b0, 1'b1));
		directed_rows.push_back(frame_row(1'b0, 1'b1, '1, '1, SAMPLE_MAX, SAMPLE_MIN,
			CHK_ZERO, PH_RISE, 1'b1, 1'b0));
		directed_rows.push_back(frame_row(1'b0, 1'b0, SAMPLE_MIN, '1, SAMPLE_MAX, '0,
			CHK_PASS, PH_IDLE, 1'b0, 1'b0));
		// short ramps through the middle of the table, checked by the model
		directed_rows.push_back(reg_row(CFG_FALL_LEN, 17'd4));
		directed_rows.push_back(reg_row(CFG_HOLD_LEN, 17'd2));
		directed_rows.push_back(reg_row(CFG_RISE_LEN, 17'd4));
		directed_rows.push_back(reg_row(CFG_FALL_STEP, 17'd16384));
		directed_rows.push_back(reg_row(CFG_RISE_STEP, 17'd16384));
		directed_rows.push_back(frame_row(1'b1, 1'b1, SAMPLE_MAX, SAMPLE_MIN, 24'hFFFFFD, 24'd3));
		directed_rows.push_back(frame_row(1'b0, 1'b0, SAMPLE_MIN, SAMPLE_MAX, 24'hFFFFFF, 24'd1));
		directed_rows.push_back(frame_row(1'b0, 1'b0, 24'h400001, 24'hBFFFFF, 24'h000003, 24'hFFFFF9));
		directed_rows.push_back(frame_row(1'b1, 1'b0, 24'h123457, 24'hEDCBA9, SAMPLE_MAX, SAMPLE_MIN));
		directed_rows.push_back(frame_row(1'b0, 1'b0, SAMPLE_MAX, SAMPLE_MIN, '1, SAMPLE_ONE));
		directed_rows.push_back(frame_row(1'b0, 1'b0, SAMPLE_MAX, SAMPLE_MIN, '1, SAMPLE_ONE));
		directed_rows.push_back(frame_row(1'b0, 1'b0, SAMPLE_MAX, SAMPLE_MIN, 24'hFFFFFB, 24'd5));
		directed_rows.push_back(frame_row(1'b0, 1'b0, SAMPLE_MIN, SAMPLE_MAX, 24'h2AAAAB, 24'hD55555));
		directed_rows.push_back(frame_row(1'b0, 1'b0, 24'h000007, 24'hFFFFF1, SAMPLE_MAX, SAMPLE_MIN));
		directed_rows.push_back(frame_row(1'b0, 1'b0, SAMPLE_MAX, SAMPLE_MIN, '1, SAMPLE_ONE));
		directed_rows.push_back(frame_row(1'b0, 1'b1, 24'h654321, 24'h9ABCDF, '0, '1));

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// walk the table: writes only once every frame has come back
		prev_reg = 1'b0;
		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			if (row.is_reg) begin
				if (!prev_reg) drain_frames();
				write_reg(row.idx, row.val);
			end else begin
				if (prev_reg) cfg_valid <= 1'b0;
				send_frame(row.f);
				want = envelope_predict(row.f);
				if (row.chk != CHK_PREDICT) begin
					want.ch = (row.chk == CHK_PASS) ? row.f.ch : '0;
					want.ph = row.ph;
					want.done = row.done;
					want.mode = row.mode;
				end
				expected_frames.push_back(want);
				frames_sent++;
			end
			prev_reg = row.is_reg;
		end

		// random phases: reprogram the ramps, then stream a batch of frames
		phase_no = 0;
		while (frames_sent < FRAME_TARGET) begin
			drain_frames();
			case (phase_no)
				0: begin
					// longest ramps with the slowest steps
					fl = CFG_DATA_W'(16'hFFFF);
					hl = CFG_DATA_W'(16'hFFFF);
					rl = CFG_DATA_W'(16'hFFFF);
					fs = CFG_DATA_W'(1);
					rs = CFG_DATA_W'(1);
					batch = 90;
				end
				1: begin
					// unity steps on short ramps
					fl = CFG_DATA_W'($urandom_range(1, 6));
					hl = CFG_DATA_W'($urandom_range(1, 6));
					rl = CFG_DATA_W'($urandom_range(1, 6));
					fs = POS_ONE;
					rs = POS_ONE;
					batch = 40;
				end
				default: begin
					fl = random_length();
					hl = random_length();
					rl = random_length();
					fs = random_step(fl);
					rs = random_step(rl);
					batch = $urandom_range(8, 64);
				end
			endcase
			write_reg(CFG_FALL_LEN, fl);
			write_reg(CFG_HOLD_LEN, hl);
			write_reg(CFG_RISE_LEN, rl);
			write_reg(CFG_FALL_STEP, fs);
			write_reg(CFG_RISE_STEP, rs);
			if ($urandom_range(0, 4) == 0)
				write_reg(CFG_IDX_W'($urandom_range(CFG_NONE_LO, CFG_NONE_HI)),
					CFG_DATA_W'($urandom));
			cfg_valid <= 1'b0;
			// one long receiver hold-off with the sender pushing without gaps
			if (phase_no == 3) begin
				hold_off_req = 1'b1;
				burst_left = 400;
				batch = 300;
			end
			repeat (batch) begin
				f = random_frame();
				send_frame(f);
				expected_frames.push_back(envelope_predict(f));
				frames_sent++;
			end
			phase_no++;
		end

		drain_frames();
		repeat (SETTLE) @(posedge clk);
		$display("run: %0d frames over %0d random ramp settings, %0d switches completed",
			frames_sent, phase_no, switches_done);
		$display("run: %0d register writes, %0d result beats checked, %0d mismatches",
			reg_writes, beats_checked, fail_count);
		if (fail_count == 0 && expected_frames.size() == 0) begin
			$display("sine_ramp_switch_envelope_core_tb: clean");
		end else begin
			$display("sine_ramp_switch_envelope_core_tb: errors");
		end
		$finish;
	end

	// ------------------------------------------------------------------
	// Receiver: stall on a random 8-bit pattern per stretch, plus one long
	// hold-off so the pipe fills and the input side backs up
	// ------------------------------------------------------------------
	initial begin : rx_pattern
		logic [7:0] pat;
		int         span;
		wait (arst_n);
		forever begin
			pat = ($urandom_range(0, 2) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
			span = $urandom_range(16, 160);
			for (int c = 0; c < span; c++) begin
				@(posedge clk);
				if (hold_off_req && !hold_off_done) begin
					m_axis_tready <= 1'b0;
					repeat (HOLD_OFF) @(posedge clk);
					hold_off_done = 1'b1;
				end else begin
					m_axis_tready <= pat[c % 8];
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Result check: compare each output beat with the oldest expected frame
	// ------------------------------------------------------------------
	always @(posedge clk) begin : result_check
		out_frame_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.ch = m_axis_tdata[4*SW-1:0];
			got.ph = phase_t'(m_axis_tuser[1:0]);
			got.mode = m_axis_tuser[2];
			got.done = m_axis_tlast;
			if (expected_frames.size() == 0) begin
				$error("result beat with no frame outstanding");
				fail_count++;
			end else begin
				want = expected_frames.pop_front();
				beats_checked++;
				for (int j = 0; j < 4; j++) begin
					if (got.ch[j] !== want.ch[j]) begin
						$error("%s: expected %0d, got %0d", chan_name[j],
							$signed(want.ch[j]), $signed(got.ch[j]));
						fail_count++;
					end
				end
				if (got.ph !== want.ph) begin
					$error("phase: expected %0d, got %0d", want.ph, got.ph);
					fail_count++;
				end
				if (got.done !== want.done) begin
					$error("done_res: expected %0d, got %0d", want.done, got.done);
					fail_count++;
				end
				if (got.mode !== want.mode) begin
					$error("current_mode: expected %0d, got %0d", want.mode, got.mode);
					fail_count++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: end the run if no beat moves on any channel for too long
	// ------------------------------------------------------------------
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
					|| (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("timeout: no beat for %0d cycles", STALL_LIMIT);
		$display("sine_ramp_switch_envelope_core_tb: errors");
		$finish;
	end

endmodule
